// File: design/ptc_pkg.sv
// Package with payload types, coefficients and helpers for the compensation pipeline.
package ptc_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [27:0] temperature_decidegrees;
      logic signed [31:0] pressure_pascal;
      logic               divide_error;
   } rsp_type;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_AC1_AC2  = 3'd0;
   localparam logic [2:0] REG_AC3_AC4  = 3'd1;
   localparam logic [2:0] REG_AC5_AC6  = 3'd2;
   localparam logic [2:0] REG_B1_B2    = 3'd3;
   localparam logic [2:0] REG_MC_MD    = 3'd4;
   localparam logic [2:0] REG_OSS      = 3'd5;

   // Fixed coefficients of the integer compensation
   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] B7_SCALE    = 32'd50000;
   localparam logic [31:0] P_X1_COEF   = 32'd3038;
   localparam logic [31:0] P_X2_COEF   = 32'hFFFF_E343;  // -7357
   localparam logic [31:0] P_ROUND     = 32'd3791;
   localparam logic [31:0] B7_LIMIT    = 32'h8000_0000;
   localparam logic [31:0] B4_BIAS     = 32'd32768;
   localparam logic [3:0]  UP_SHIFT    = 4'd8;

   // Sideband that rides along the temperature divider
   typedef struct packed {
      logic [31:0] x1;
      logic [23:0] up;
      logic        err;
      logic        neg;
   } d1_side_type;

   // Sideband that rides along the pressure divider
   typedef struct packed {
      logic [27:0] t;
      logic        err;
      logic        dbl;
   } d2_side_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
      return $unsigned($signed(v) >>> n);
   endfunction

endpackage

// File: design/ptc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module ptc_div #(
   parameter int W      = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [W-1:0]      dividend,
   input  logic [W-1:0]      divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [W-1:0]      quotient,
   output logic [SIDE_W-1:0] side_out
);

   logic [W-1:0]      valid_ff;
   logic [W-1:0]      rem_ff  [W];
   logic [W-1:0]      dvd_ff  [W];
   logic [W-1:0]      dvs_ff  [W];
   logic [SIDE_W-1:0] side_ff [W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W-1:0]      rem_prev;
      logic [W-1:0]      dvd_prev;
      logic [W-1:0]      dvs_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [W:0]        trial;
      logic [W:0]        diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign dvd_prev   = dividend;
         assign dvs_prev   = divisor;
         assign side_prev  = side_in;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign dvd_prev   = dvd_ff[k-1];
         assign dvs_prev   = dvs_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // Shift in next dividend bit and try to subtract
      assign trial = {rem_prev, dvd_prev[W-1]};
      assign diff  = trial - {1'b0, dvs_prev};
      assign ge    = (trial >= {1'b0, dvs_prev});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
            dvd_ff[k]  <= {dvd_prev[W-2:0], ge};
            dvs_ff[k]  <= dvs_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign quotient  = dvd_ff[W-1];
   assign side_out  = side_ff[W-1];

endmodule

// File: design/pressure_temperature_compensation.sv
// Throughput: one request per cycle while the response is not stalled;
// two 32-stage bit-per-stage dividers and a chain of multiplier stages set
// the depth, none limits the rate.
// A response stall holds the whole pipeline and the request side together.
// Reset (synchronous) clears all valid bits and sets every CSR to zero.
module pressure_temperature_compensation (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ptc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ptc_pkg::rsp_type rsp_data,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_index,
   input  logic [31:0]     csr_write_data
);

   localparam int W = 32;

   // CSR file
   logic [31:0] ac1_ac2_ff, ac3_ac4_ff, ac5_ac6_ff, b1_b2_ff, mc_md_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ac2_ff <= '0;
         ac3_ac4_ff <= '0;
         ac5_ac6_ff <= '0;
         b1_b2_ff   <= '0;
         mc_md_ff   <= '0;
         oss_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ptc_pkg::REG_AC1_AC2: ac1_ac2_ff <= csr_write_data;
            ptc_pkg::REG_AC3_AC4: ac3_ac4_ff <= csr_write_data;
            ptc_pkg::REG_AC5_AC6: ac5_ac6_ff <= csr_write_data;
            ptc_pkg::REG_B1_B2:   b1_b2_ff   <= csr_write_data;
            ptc_pkg::REG_MC_MD:   mc_md_ff   <= csr_write_data;
            ptc_pkg::REG_OSS:     oss_ff     <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Calibration words
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = ptc_pkg::sx16(ac1_ac2_ff[31:16]);
   assign ac2 = ptc_pkg::sx16(ac1_ac2_ff[15:0]);
   assign ac3 = ptc_pkg::sx16(ac3_ac4_ff[31:16]);
   assign ac4 = {16'b0, ac3_ac4_ff[15:0]};
   assign ac5 = {16'b0, ac5_ac6_ff[31:16]};
   assign ac6 = {16'b0, ac5_ac6_ff[15:0]};
   assign b1  = ptc_pkg::sx16(b1_b2_ff[31:16]);
   assign b2  = ptc_pkg::sx16(b1_b2_ff[15:0]);
   assign mc  = ptc_pkg::sx16(mc_md_ff[31:16]);
   assign md  = ptc_pkg::sx16(mc_md_ff[15:0]);

   // Global advance: hold everything while the response is stalled
   logic           enable;
   logic           rsp_valid_ff;
   ptc_pkg::rsp_type rsp_data_ff;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // Stage a: raw temperature product
   logic        a_valid_ff;
   logic [31:0] a_x1_ff, a_x1_in;
   logic [23:0] a_up_ff;
   assign a_x1_in = ptc_pkg::asr32(({16'b0, req_data.raw_temperature} - ac6) * ac5, 5'd15);

   // Stage b: temperature divisor and operand magnitudes
   logic        b_valid_ff;
   logic [31:0] b_num_ff, b_den_ff, b_num_in, b_den_in, b_a, b_d;
   ptc_pkg::d1_side_type b_side_ff, b_side_in;
   always_comb begin
      b_a            = mc << 11;
      b_d            = a_x1_ff + md;
      b_num_in       = b_a[31] ? (32'd0 - b_a) : b_a;
      b_den_in       = b_d[31] ? (32'd0 - b_d) : b_d;
      b_side_in.x1   = a_x1_ff;
      b_side_in.up   = a_up_ff;
      b_side_in.err  = (b_d == 32'd0);
      b_side_in.neg  = b_a[31] ^ b_d[31];
   end

   // Temperature divider
   logic        d1_valid;
   logic [31:0] d1_q;
   logic [$bits(ptc_pkg::d1_side_type)-1:0] d1_side_raw;
   ptc_pkg::d1_side_type d1_side;
   assign d1_side = d1_side_raw;

   ptc_div #(.W(W), .SIDE_W($bits(ptc_pkg::d1_side_type))) u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (b_valid_ff),
      .dividend (b_num_ff),
      .divisor  (b_den_ff),
      .side_in  (b_side_ff),
      .out_valid(d1_valid),
      .quotient (d1_q),
      .side_out (d1_side_raw)
   );

   // Stage c: B5, temperature, B6
   logic        c_valid_ff, c_err_ff;
   logic [31:0] c_b6_ff, c_b5, c_x2, c_tw;
   logic [27:0] c_t_ff;
   logic [23:0] c_up_ff;
   always_comb begin
      c_x2 = d1_side.neg ? (32'd0 - d1_q) : d1_q;
      c_b5 = d1_side.x1 + c_x2;
      c_tw = ptc_pkg::asr32(c_b5 + 32'd8, 5'd4);
   end

   // Stage d: products of B6
   logic        d_valid_ff, d_err_ff;
   logic [27:0] d_t_ff;
   logic [23:0] d_up_ff;
   logic [31:0] d_sqp_ff, d_ac2b6_ff, d_ac3b6_ff;

   // Stage e: products of B6 squared
   logic        e_valid_ff, e_err_ff;
   logic [27:0] e_t_ff;
   logic [23:0] e_up_ff;
   logic [31:0] e_sq, e_b2sq_ff, e_b1sq_ff, e_x2_ff, e_x1c_ff;
   assign e_sq = ptc_pkg::asr32(d_sqp_ff, 5'd12);

   // Stage f: B3 and X3
   logic        f_valid_ff, f_err_ff;
   logic [27:0] f_t_ff;
   logic [23:0] f_up_ff;
   logic [31:0] f_b3_ff, f_x3p_ff, f_b3_in, f_x3p_in, f_x3;
   always_comb begin
      f_x3     = e_b2sq_ff + e_x2_ff;
      f_b3_in  = ptc_pkg::asr32((((ac1 << 2) + f_x3) << oss_ff) + 32'd2, 5'd2);
      f_x3p_in = ptc_pkg::asr32(e_x1c_ff + ptc_pkg::asr32(e_b1sq_ff, 5'd16) + 32'd2, 5'd2);
   end

   // Stage g: B4 and B7
   logic        g_valid_ff, g_err_ff;
   logic [27:0] g_t_ff;
   logic [31:0] g_b4_ff, g_b7_ff, g_upsh, g_b4p;
   always_comb begin
      g_upsh = {8'b0, f_up_ff} >> (ptc_pkg::UP_SHIFT - {2'b0, oss_ff});
      g_b4p  = ac4 * (f_x3p_ff + ptc_pkg::B4_BIAS);
   end

   // Stage h: pressure divider operands
   logic        h_valid_ff;
   logic [31:0] h_num_ff, h_den_ff;
   ptc_pkg::d2_side_type h_side_ff, h_side_in;
   logic        h_dbl;
   always_comb begin
      h_dbl         = (g_b7_ff < ptc_pkg::B7_LIMIT);
      h_side_in.t   = g_t_ff;
      h_side_in.err = g_err_ff || (g_b4_ff == 32'd0);
      h_side_in.dbl = h_dbl;
   end

   // Pressure divider
   logic        d2_valid;
   logic [31:0] d2_q;
   logic [$bits(ptc_pkg::d2_side_type)-1:0] d2_side_raw;
   ptc_pkg::d2_side_type d2_side;
   assign d2_side = d2_side_raw;

   ptc_div #(.W(W), .SIDE_W($bits(ptc_pkg::d2_side_type))) u_div_pres (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (h_valid_ff),
      .dividend (h_num_ff),
      .divisor  (h_den_ff),
      .side_in  (h_side_ff),
      .out_valid(d2_valid),
      .quotient (d2_q),
      .side_out (d2_side_raw)
   );

   // Stage i: raw pressure and correction products
   logic        i_valid_ff, i_err_ff;
   logic [27:0] i_t_ff;
   logic [31:0] i_p, i_q8, i_p_ff, i_qq_ff, i_x2_ff;
   always_comb begin
      i_p  = d2_side.dbl ? d2_q : (d2_q << 1);
      i_q8 = ptc_pkg::asr32(i_p, 5'd8);
   end

   // Stage j: quadratic correction term
   logic        j_valid_ff, j_err_ff;
   logic [27:0] j_t_ff;
   logic [31:0] j_p_ff, j_x1_ff, j_x2_ff;

   // Stage k: final sum into the response register
   ptc_pkg::rsp_type k_rsp_in;
   logic [31:0] k_p;
   always_comb begin
      k_p = j_p_ff + ptc_pkg::asr32(j_x1_ff + j_x2_ff + ptc_pkg::P_ROUND, 5'd4);
      k_rsp_in.divide_error            = j_err_ff;
      k_rsp_in.temperature_decidegrees = j_err_ff ? '0 : $signed(j_t_ff);
      k_rsp_in.pressure_pascal         = j_err_ff ? '0 : $signed(k_p);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         i_valid_ff   <= 1'b0;
         j_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff   <= req_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= d1_valid;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         f_valid_ff   <= e_valid_ff;
         g_valid_ff   <= f_valid_ff;
         h_valid_ff   <= g_valid_ff;
         i_valid_ff   <= d2_valid;
         j_valid_ff   <= i_valid_ff;
         rsp_valid_ff <= j_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (enable) begin
         a_x1_ff    <= a_x1_in;
         a_up_ff    <= req_data.raw_pressure;

         b_num_ff   <= b_num_in;
         b_den_ff   <= b_den_in;
         b_side_ff  <= b_side_in;

         c_b6_ff    <= c_b5 - ptc_pkg::B6_OFFSET;
         c_t_ff     <= c_tw[27:0];
         c_up_ff    <= d1_side.up;
         c_err_ff   <= d1_side.err;

         d_sqp_ff   <= c_b6_ff * c_b6_ff;
         d_ac2b6_ff <= ac2 * c_b6_ff;
         d_ac3b6_ff <= ac3 * c_b6_ff;
         d_t_ff     <= c_t_ff;
         d_up_ff    <= c_up_ff;
         d_err_ff   <= c_err_ff;

         e_b2sq_ff  <= ptc_pkg::asr32(b2 * e_sq, 5'd11);
         e_b1sq_ff  <= b1 * e_sq;
         e_x2_ff    <= ptc_pkg::asr32(d_ac2b6_ff, 5'd11);
         e_x1c_ff   <= ptc_pkg::asr32(d_ac3b6_ff, 5'd13);
         e_t_ff     <= d_t_ff;
         e_up_ff    <= d_up_ff;
         e_err_ff   <= d_err_ff;

         f_b3_ff    <= f_b3_in;
         f_x3p_ff   <= f_x3p_in;
         f_t_ff     <= e_t_ff;
         f_up_ff    <= e_up_ff;
         f_err_ff   <= e_err_ff;

         g_b4_ff    <= g_b4p >> 15;
         g_b7_ff    <= (g_upsh - f_b3_ff) * (ptc_pkg::B7_SCALE >> oss_ff);
         g_t_ff     <= f_t_ff;
         g_err_ff   <= f_err_ff;

         h_num_ff   <= h_dbl ? (g_b7_ff << 1) : g_b7_ff;
         h_den_ff   <= g_b4_ff;
         h_side_ff  <= h_side_in;

         i_p_ff     <= i_p;
         i_qq_ff    <= i_q8 * i_q8;
         i_x2_ff    <= ptc_pkg::asr32(ptc_pkg::P_X2_COEF * i_p, 5'd16);
         i_t_ff     <= d2_side.t;
         i_err_ff   <= d2_side.err;

         j_x1_ff    <= ptc_pkg::asr32(i_qq_ff * ptc_pkg::P_X1_COEF, 5'd16);
         j_p_ff     <= i_p_ff;
         j_x2_ff    <= i_x2_ff;
         j_t_ff     <= i_t_ff;
         j_err_ff   <= i_err_ff;

         rsp_data_ff <= k_rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: design/ptc_checker.sv
// Port-level checker for the compensation pipeline and its bind.
module ptc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ptc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ptc_pkg::rsp_type rsp_data
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Request side stalls exactly when the response is held
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow response hold");

   // A flagged division gives zero results
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_error) |->
         (rsp_data.temperature_decidegrees == '0 && rsp_data.pressure_pascal == '0))
      else $error("divide error with nonzero result");

   // A held response stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("held response changed");

   // A stalled request stays valid and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
      else $error("stalled request changed");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
